// ----- src/sorted_priority_task_queue_macros.svh -----
// Assertion macros shared by the sorted priority task queue.
`ifndef SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define SPQ_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("sorted_priority_task_queue: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define SPQ_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sorted_priority_task_queue: next-cycle check failed");

`endif

// ----- src/spq_pkg.sv -----
// Package with the types, codes and defaults of the sorted priority task queue.
package spq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int PRIO_W       = 16;
    localparam int TAG_W        = 16;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes.
    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_LIST   = 2'd2;
    localparam cmd_t CMD_NONE   = 2'd3;

    // Status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Control of one result word handed to the output register.
    typedef struct packed {
        logic    load;
        status_t status;
        logic    last;
    } resp_ctl_t;

endpackage

// ----- src/spq_if.sv -----
// Valid/ready channel interfaces for command words and result words.
interface spq_req_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    cmd_t                     command;
    logic signed [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]         task_tag;

    modport source (output valid, output command, output priority_req, output task_tag,
                    input ready);
    modport sink (input valid, input command, input priority_req, input task_tag,
                  output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]         out_tag;
    logic                     last;

    modport source (output valid, output status, output out_priority, output out_tag,
                    output last, input ready);
    modport sink (input valid, input status, input out_priority, input out_tag,
                  input last, output ready);
endinterface

// ----- src/spq_mem.sv -----
// Simple dual-port entry memory with one write port and a registered read port.
module spq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- src/spq_out.sv -----
// Output register that holds one result word until the sink takes it.
module spq_out #(
    parameter int TAG_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::resp_ctl_t                ctl,
    input  logic signed [spq_pkg::PRIO_W-1:0] prio,
    input  logic [TAG_BITS-1:0]               tag,
    output logic                              free,
    spq_rsp_if.source                         result
);
    import spq_pkg::*;

    localparam int WIDE = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;

    logic                     valid_reg;
    logic                     valid_next;
    status_t                  status_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    logic [TAG_BITS-1:0]      tag_reg;
    logic                     last_reg;
    logic [WIDE-1:0]          tag_wide;

    // The register can take a new word when empty or when its word leaves now.
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is captured with each load.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            status_reg <= ctl.status;
            last_reg   <= ctl.last;
            prio_reg   <= prio;
            tag_reg    <= tag;
        end
    end

    assign tag_wide            = WIDE'(tag_reg);
    assign result.valid        = valid_reg;
    assign result.status       = status_reg;
    assign result.out_priority = prio_reg;
    assign result.out_tag      = tag_wide[TAG_W-1:0];
    assign result.last         = last_reg;
endmodule

// ----- src/spq_ctrl.sv -----
// Sequencer that inserts, removes and lists entries by read-modify-write of the memory.
module spq_ctrl #(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    spq_req_if.sink                                 request,
    input  logic                                    out_free,
    output spq_pkg::resp_ctl_t                      resp,
    output logic signed [spq_pkg::PRIO_W-1:0]       resp_prio,
    output logic [TAG_BITS-1:0]                     resp_tag,
    output logic                                    wr_en,
    output logic [$clog2(DEPTH)-1:0]                wr_addr,
    output logic [spq_pkg::PRIO_W+TAG_BITS-1:0]     wr_data,
    output logic                                    rd_en,
    output logic [$clog2(DEPTH)-1:0]                rd_addr,
    input  logic [spq_pkg::PRIO_W+TAG_BITS-1:0]     rd_data,
    output logic [$clog2(DEPTH+1)-1:0]              fill
);
    import spq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int EW   = PRIO_W + TAG_BITS;
    localparam int WIDE = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_INS_CHK   = 7'b0000010,
        S_INS_PUT   = 7'b0000100,
        S_REM_HEAD  = 7'b0001000,
        S_REM_SHIFT = 7'b0010000,
        S_LIST      = 7'b0100000,
        S_RESP      = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;
    status_t                  rsp_stat_reg, rsp_stat_next;
    logic signed [PRIO_W-1:0] rsp_prio_reg, rsp_prio_next;
    logic [TAG_BITS-1:0]      rsp_tag_reg, rsp_tag_next;

    logic [WIDE-1:0]          tag_wide_in;
    logic signed [PRIO_W-1:0] rd_prio;
    logic [TAG_BITS-1:0]      rd_tag;
    logic [CW-1:0]            idx_dec;
    logic [CW-1:0]            idx_dec2;
    logic [CW-1:0]            idx_inc;
    logic [CW-1:0]            count_dec;

    assign tag_wide_in = WIDE'(request.task_tag);
    assign rd_prio     = rd_data[PRIO_W-1:0];
    assign rd_tag      = rd_data[EW-1:PRIO_W];
    assign idx_dec     = CW'(idx_reg - 1'b1);
    assign idx_dec2    = CW'(idx_reg - 2'd2);
    assign idx_inc     = CW'(idx_reg + 1'b1);
    assign count_dec   = CW'(count_reg - 1'b1);

    assign request.ready = (state_reg == S_IDLE);
    assign fill          = count_reg;

    // Command sequencing; each step issues at most one read and one write.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        prio_next     = prio_reg;
        tag_next      = tag_reg;
        rsp_stat_next = rsp_stat_reg;
        rsp_prio_next = rsp_prio_reg;
        rsp_tag_next  = rsp_tag_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[AW-1:0];
        wr_data       = {tag_reg, prio_reg};
        rd_en         = 1'b0;
        rd_addr       = '0;
        resp          = '0;
        resp_prio     = '0;
        resp_tag      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    prio_next     = request.priority_req;
                    tag_next      = tag_wide_in[TAG_BITS-1:0];
                    rsp_stat_next = ST_OK;
                    rsp_prio_next = '0;
                    rsp_tag_next  = '0;
                    idx_next      = '0;
                    case (request.command)
                        CMD_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                rsp_stat_next = ST_FULL;
                                state_next    = S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                // Start at the tail and walk toward the head.
                                idx_next   = count_reg;
                                rd_en      = 1'b1;
                                rd_addr    = count_dec[AW-1:0];
                                state_next = S_INS_CHK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_stat_next = ST_EMPTY;
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_REM_HEAD;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_stat_next = ST_EMPTY;
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_CHK:
            begin
                // A strictly larger priority moves up one slot; equal ones stay ahead.
                if (rd_prio > prio_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    idx_next = idx_dec;
                    if (idx_dec == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_dec2[AW-1:0];
                    end
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT:
            begin
                wr_en         = 1'b1;
                count_next    = CW'(count_reg + 1'b1);
                rsp_stat_next = ST_OK;
                state_next    = S_RESP;
            end

            S_REM_HEAD:
            begin
                rsp_prio_next = rd_prio;
                rsp_tag_next  = rd_tag;
                rsp_stat_next = ST_OK;
                idx_next      = CW'(1);
                if (count_reg == CW'(1))
                begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(1);
                    state_next = S_REM_SHIFT;
                end
            end

            S_REM_SHIFT:
            begin
                // Move each remaining entry one slot toward the head.
                wr_en    = 1'b1;
                wr_addr  = idx_dec[AW-1:0];
                wr_data  = rd_data;
                idx_next = idx_inc;
                if (idx_inc == count_reg)
                begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[AW-1:0];
                end
            end

            S_LIST:
            begin
                // Stream one entry per cycle while the output register has room.
                if (out_free)
                begin
                    resp.load   = 1'b1;
                    resp.status = ST_OK;
                    resp.last   = (idx_inc == count_reg);
                    resp_prio   = rd_prio;
                    resp_tag    = rd_tag;
                    if (idx_inc == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[AW-1:0];
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    resp.load   = 1'b1;
                    resp.status = rsp_stat_reg;
                    resp.last   = 1'b1;
                    resp_prio   = rsp_prio_reg;
                    resp_tag    = rsp_tag_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working payload.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        prio_reg     <= prio_next;
        tag_reg      <= tag_next;
        rsp_stat_reg <= rsp_stat_next;
        rsp_prio_reg <= rsp_prio_next;
        rsp_tag_reg  <= rsp_tag_next;
    end
endmodule

// ----- src/sorted_priority_task_queue.sv -----
// Sorted priority task queue: a bounded list of (priority, tag) entries held in one
// memory in ascending priority order, equal priorities kept in arrival order. Commands
// are taken one at a time; the memory has one write and one registered read port, and
// each sequencer step does at most one read and one write. Insert walks from the tail
// toward the head, moving each entry of strictly larger priority up one slot, and then
// writes the new entry; a full queue is reported without a search. Remove reads the head
// and shifts each remaining entry one slot toward the head. List streams one result word
// per cycle while the sink keeps up; remove and list of an empty queue report an empty
// status. A finished result waits in an output register, so the next command is taken
// while it is still pending. The memory needs no clearing after reset.
`include "sorted_priority_task_queue_macros.svh"

module sorted_priority_task_queue #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   request,
    spq_rsp_if.source result
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = PRIO_W + TAG_BITS;

    resp_ctl_t                resp;
    logic signed [PRIO_W-1:0] resp_prio;
    logic [TAG_BITS-1:0]      resp_tag;
    logic                     out_free;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [EW-1:0]            wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [EW-1:0]            rd_data;
    logic [CW-1:0]            fill;
    logic                     cmd_taken;

    spq_ctrl #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .out_free  (out_free),
        .resp      (resp),
        .resp_prio (resp_prio),
        .resp_tag  (resp_tag),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .fill      (fill)
    );

    spq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spq_out #(
        .TAG_BITS (TAG_BITS)
    ) u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (resp),
        .prio   (resp_prio),
        .tag    (resp_tag),
        .free   (out_free),
        .result (result)
    );

    // A command word that starts real work.
    assign cmd_taken = request.valid && request.ready && (request.command != CMD_NONE);

    // A word is loaded only when the output register is empty or draining.
    `SPQ_ASSERT_SAME(a_load_when_free, resp.load, (!result.valid || result.ready))
    // A full report goes out only with every slot taken.
    `SPQ_ASSERT_SAME(a_full_at_depth, (resp.load && resp.status == ST_FULL), (fill == CW'(DEPTH)))
    // An empty report goes out only with no entry queued.
    `SPQ_ASSERT_SAME(a_empty_at_zero, (resp.load && resp.status == ST_EMPTY), (fill == '0))
    // Every valid command keeps the block busy in the next cycle.
    `SPQ_ASSERT_NEXT(a_busy_after_cmd, cmd_taken, !request.ready)
endmodule
